[src/afu_pkg.sv]
package afu_pkg;

  // Sample and result formats
  localparam int INPUT_BITS = 12;
  localparam int ACT_W      = 16;
  localparam int SLOPE_W    = 13;
  localparam int KIND_W     = 3;
  localparam int Q_FRAC     = 12;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENTITY = 3'd0,
    KIND_RELU     = 3'd1,
    KIND_LEAKY    = 3'd2,
    KIND_TANH     = 3'd3,
    KIND_SIGMOID  = 3'd4
  } afu_kind_e;

  // Magnitude handling: transcendental kinds clamp |x| to 12 bits
  localparam int EXP_BITS    = 12;
  localparam int EXP_MAX     = 2 ** EXP_BITS - 1;
  localparam int EXP_DIGIT_W = 4;
  localparam int EXP_DIGIT_N = 2 ** EXP_DIGIT_W;
  localparam int EXP_DIGITS  = EXP_BITS / EXP_DIGIT_W;
  localparam int MAG_W       = (INPUT_BITS > EXP_BITS) ? INPUT_BITS : EXP_BITS;
  localparam int SIG_CUTOFF  = 1280;  // |x| = 5.0 in Q4.8

  // Internal fixed point: unsigned, FRAC fraction bits, values in [0, 2]
  localparam int FRAC   = 32;
  localparam int UNIT_W = FRAC + 1;
  localparam int DEN_W  = FRAC + 2;
  localparam int REM_W  = FRAC + 3;
  localparam int QUO_W  = FRAC + 1;

  localparam logic [UNIT_W-1:0] UNIT_ONE = {1'b1, {FRAC{1'b0}}};
  localparam logic [DEN_W-1:0]  DEN_ONE  = {2'b01, {FRAC{1'b0}}};

  // Reciprocal divider pipeline
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = QUO_W / DIV_PER_STAGE;

  // Rounding back to Q12
  localparam int ACT_SHIFT  = FRAC - Q_FRAC;
  localparam int TANH_SHIFT = ACT_SHIFT - 2;

  localparam logic [ACT_W-1:0]   ACT_MAX     = {1'b0, {(ACT_W-1){1'b1}}};
  localparam logic [ACT_W-1:0]   ACT_MIN     = {1'b1, {(ACT_W-1){1'b0}}};
  localparam logic [SLOPE_W-1:0] SLOPE_ONE   = SLOPE_W'(2 ** Q_FRAC);
  localparam logic [SLOPE_W-1:0] SLOPE_LEAKY = SLOPE_W'(410);

  // Per-word control carried alongside the datapath
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               neg;
    logic               cut;
    logic [ACT_W-1:0]   act;
    logic [SLOPE_W-1:0] slope;
  } afu_side_t;

  // a * b with FRAC fraction bits, rounded half up
  function automatic logic [UNIT_W-1:0] mul_round(input logic [UNIT_W-1:0] a,
                                                  input logic [UNIT_W-1:0] b);
    logic [2*UNIT_W-1:0] p;
    p = (2*UNIT_W)'(a) * (2*UNIT_W)'(b) + ((2*UNIT_W)'(1) << (FRAC - 1));
    return p[FRAC+UNIT_W-1:FRAC];
  endfunction

endpackage

[src/afu_front.sv]
module afu_front import afu_pkg::*; (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [KIND_W-1:0]                      kind_i,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [INPUT_BITS-1:0]           sample_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [EXP_DIGITS-1:0][UNIT_W-1:0]      fac_o,
  output afu_side_t                              side_o
);

  localparam int FX      = 60;
  localparam int XW      = (INPUT_BITS + 4 > ACT_W) ? INPUT_BITS + 4 : ACT_W;
  localparam int LK_W    = INPUT_BITS + 3;
  localparam int RCP_W   = 22;
  localparam int RCP_SH  = 24;
  localparam int RCP5    = 3355444;  // ceil(2^24 / 5)
  localparam int LKQ_W   = LK_W + RCP_W - RCP_SH;
  localparam int QX      = (LKQ_W > ACT_W + 1) ? LKQ_W : ACT_W + 1;
  localparam logic signed [XW-1:0] X_MAX = XW'(32767);
  localparam logic signed [XW-1:0] X_MIN = XW'(-32768);

  // Elaboration-time Q60 helpers for the exponent tables
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (FX - 1));
    return p[FX+63:FX];
  endfunction

  // e^(-v/256), v < 4096, rounded to FRAC fraction bits
  function automatic logic [UNIT_W-1:0] exp_const(input int unsigned v);
    logic [63:0] base, pw, acc;
    int          i;
    base = (64'd1 << FX) - (64'd1 << (FX - 20)) + (64'd1 << (FX - 41));
    for (i = 0; i < 12; i++) base = fx_mul(base, base);
    acc = 64'd1 << FX;
    pw  = base;
    for (i = 0; i < EXP_BITS; i++) begin
      if (v[i]) acc = fx_mul(acc, pw);
      pw = fx_mul(pw, pw);
    end
    acc = (acc + (64'd1 << (FX - FRAC - 1))) >> (FX - FRAC);
    return acc[UNIT_W-1:0];
  endfunction

  // One table per hex digit of the clamped magnitude
  logic [UNIT_W-1:0] exp_tbl [EXP_DIGITS][EXP_DIGIT_N];

  for (genvar j = 0; j < EXP_DIGITS; j++) begin : g_dig
    for (genvar k = 0; k < EXP_DIGIT_N; k++) begin : g_ent
      localparam logic [UNIT_W-1:0] C = exp_const(k << (EXP_DIGIT_W * j));
      assign exp_tbl[j][k] = C;
    end
  end

  logic                       neg, pos, cut;
  logic [INPUT_BITS-1:0]      mag;
  logic [MAG_W-1:0]           mag_x;
  logic [EXP_BITS-1:0]        mag_c;
  logic signed [XW-1:0]       x16;
  logic [ACT_W-1:0]           act_id;
  logic [LK_W-1:0]            lk_x;
  logic [LK_W+RCP_W-1:0]      lk_p;
  logic [QX-1:0]              lk_q, lk_n;
  logic [ACT_W-1:0]           act_lk;
  afu_side_t                  side_d;
  logic [EXP_DIGITS-1:0][UNIT_W-1:0] fac_d;

  always_comb begin
    neg    = sample_i[INPUT_BITS-1];
    pos    = !neg && (sample_i != '0);
    mag    = neg ? INPUT_BITS'(-sample_i) : sample_i;
    mag_x  = MAG_W'(mag);
    mag_c  = (mag_x > MAG_W'(EXP_MAX)) ? EXP_BITS'(EXP_MAX) : mag_x[EXP_BITS-1:0];
    cut    = mag_x > MAG_W'(SIG_CUTOFF);

    x16    = signed'(XW'(sample_i)) <<< 4;
    act_id = (x16 > X_MAX) ? ACT_MAX : (x16 < X_MIN) ? ACT_MIN : x16[ACT_W-1:0];

    // round(1.6 m) = floor((8m + 2) / 5), by reciprocal multiply
    lk_x   = {mag, 3'b010};
    lk_p   = (LK_W+RCP_W)'(lk_x) * (LK_W+RCP_W)'(RCP5);
    lk_q   = QX'(lk_p[LK_W+RCP_W-1:RCP_SH]);
    lk_n   = -lk_q;
    act_lk = (lk_q > QX'(32768)) ? ACT_MIN : lk_n[ACT_W-1:0];

    side_d.kind = kind_i;
    side_d.neg  = neg;
    side_d.cut  = cut;
    case (kind_i)
      KIND_IDENTITY: begin
        side_d.act   = act_id;
        side_d.slope = SLOPE_ONE;
      end
      KIND_RELU: begin
        side_d.act   = pos ? act_id : '0;
        side_d.slope = pos ? SLOPE_ONE : '0;
      end
      KIND_LEAKY: begin
        side_d.act   = pos ? act_id : act_lk;
        side_d.slope = pos ? SLOPE_ONE : SLOPE_LEAKY;
      end
      default: begin
        side_d.act   = '0;
        side_d.slope = '0;
      end
    endcase

    for (int j = 0; j < EXP_DIGITS; j++) begin
      fac_d[j] = exp_tbl[j][mag_c[j*EXP_DIGIT_W +: EXP_DIGIT_W]];
    end
  end

  logic      valid_q;
  afu_side_t side_q;
  logic [EXP_DIGITS-1:0][UNIT_W-1:0] fac_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      side_q <= side_d;
      fac_q  <= fac_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign fac_o   = fac_q;

endmodule

[src/afu_exp.sv]
module afu_exp import afu_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [EXP_DIGITS-1:0][UNIT_W-1:0] fac_i,
  input  afu_side_t                         side_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [DEN_W-1:0]                  den_o,
  output afu_side_t                         side_o
);

  // s1: f0*f1, s2: *f2 -> e, s3: square for tanh, then 1 + u
  logic              v1_q, v2_q, v3_q;
  logic              en1, en2, en3;
  logic [UNIT_W-1:0] p_q, f2_q, e_q, u_d;
  logic [DEN_W-1:0]  den_q;
  afu_side_t         side1_q, side2_q, side3_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    u_d = (side2_q.kind == KIND_TANH) ? mul_round(e_q, e_q) : e_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && en1) begin
      p_q     <= mul_round(fac_i[0], fac_i[1]);
      f2_q    <= fac_i[2];
      side1_q <= side_i;
    end
    if (v1_q && en2) begin
      e_q     <= mul_round(p_q, f2_q);
      side2_q <= side1_q;
    end
    if (v2_q && en3) begin
      den_q   <= DEN_W'(u_d) + DEN_ONE;
      side3_q <= side2_q;
    end
  end

  assign valid_o = v3_q;
  assign den_o   = den_q;
  assign side_o  = side3_q;

endmodule

[src/afu_div_stage.sv]
module afu_div_stage import afu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [REM_W-1:0] rem_i,
  input  logic [QUO_W-1:0] quo_i,
  input  logic [DEN_W-1:0] den_i,
  input  afu_side_t        side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [REM_W-1:0] rem_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [DEN_W-1:0] den_o,
  output afu_side_t        side_o
);

  // Restoring division, a few quotient bits per stage
  logic [REM_W-1:0] rem_d, rem_q;
  logic [QUO_W-1:0] quo_d, quo_q;
  logic [DEN_W-1:0] den_q;
  logic             ge;
  logic             valid_q;
  afu_side_t        side_q;

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    ge    = 1'b0;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      ge    = rem_d >= REM_W'(den_i);
      rem_d = ge ? rem_d - REM_W'(den_i) : rem_d;
      quo_d = {quo_d[QUO_W-2:0], ge};
      rem_d = {rem_d[REM_W-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

[src/afu_back.sv]
module afu_back import afu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [QUO_W-1:0]   quo_i,
  input  afu_side_t          side_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [ACT_W-1:0]   act_o,
  output logic [SLOPE_W-1:0] slope_o
);

  // w = 1/(1+u); v = w(1-w)
  // tanh: |t| = 2w-1, t' = 4v; sigmoid: w or 1-w, s' = v
  logic               va_q, vb_q, ena, enb;
  logic [UNIT_W-1:0]  w_q, v_q;
  afu_side_t          sa_q;
  logic [DEN_W-1:0]   tw, tw_r;
  logic [UNIT_W-1:0]  sv, sv_r, vt_r, vs_r;
  logic [SLOPE_W-1:0] tanh_mag, sig_mag;
  logic [ACT_W-1:0]   tanh_pos, act_d;
  logic [SLOPE_W-1:0] slope_d;
  logic [ACT_W-1:0]   act_q;
  logic [SLOPE_W-1:0] slope_q;

  assign enb     = !vb_q || ready_i;
  assign ena     = !va_q || enb;
  assign ready_o = ena;

  always_comb begin
    tw       = {w_q, 1'b0} - DEN_ONE;
    tw_r     = tw + (DEN_W'(1) << (ACT_SHIFT - 1));
    tanh_mag = SLOPE_W'(tw_r >> ACT_SHIFT);
    tanh_pos = ACT_W'(tanh_mag);

    sv       = sa_q.neg ? UNIT_ONE - w_q : w_q;
    sv_r     = sv + (UNIT_W'(1) << (ACT_SHIFT - 1));
    sig_mag  = SLOPE_W'(sv_r >> ACT_SHIFT);

    vt_r     = v_q + (UNIT_W'(1) << (TANH_SHIFT - 1));
    vs_r     = v_q + (UNIT_W'(1) << (ACT_SHIFT - 1));

    case (sa_q.kind)
      KIND_TANH: begin
        act_d   = sa_q.neg ? ACT_W'(-tanh_pos) : tanh_pos;
        slope_d = SLOPE_W'(vt_r >> TANH_SHIFT);
      end
      KIND_SIGMOID: begin
        act_d   = ACT_W'(sig_mag);
        slope_d = sa_q.cut ? '0 : SLOPE_W'(vs_r >> ACT_SHIFT);
      end
      default: begin
        act_d   = sa_q.act;
        slope_d = sa_q.slope;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ena) va_q <= valid_i;
      if (enb) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ena) begin
      w_q  <= quo_i;
      v_q  <= mul_round(quo_i, UNIT_ONE - quo_i);
      sa_q <= side_i;
    end
    if (va_q && enb) begin
      act_q   <= act_d;
      slope_q <= slope_d;
    end
  end

  assign valid_o = vb_q;
  assign act_o   = act_q;
  assign slope_o = slope_q;

endmodule

[src/activation_function_unit.sv]
// Activation function unit: one signed Q4.8 sample in, activation (signed Q4.12)
// and derivative (unsigned Q1.12, 4096 = 1.0) out, for the kind in the config reg:
// identity, relu, leaky relu (slope 0.1), tanh, logistic sigmoid.
//
// Channels: sample_valid_i/sample_ready_o carry one word with sample_in_i;
// result_valid_o/result_ready_i carry one word with activation_out_o and
// slope_out_o. A word moves when valid and ready are both high.
// Config: cfg_we_i writes cfg_wdata_i into the kind register.
// Change it only while no word is in flight. Kinds 5..7 return zeros.
//
// The pipeline has 1 input/table stage, 3 exponent multiply stages,
// 11 reciprocal divider stages (3 quotient bits each) and 2 output stages.
// Throughput is one word per clock; every stage holds its own valid bit.
// When the receiver stalls, words pack into empty stages; input ready drops
// only once the whole pipeline is full, and nothing is lost or repeated.
// Reset clears all valid bits and sets the kind to identity.
module activation_function_unit import afu_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [KIND_W-1:0]            cfg_wdata_i,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic signed [INPUT_BITS-1:0] sample_in_i,
  output logic                         result_valid_o,
  input  logic                         result_ready_i,
  output logic signed [ACT_W-1:0]      activation_out_o,
  output logic [SLOPE_W-1:0]           slope_out_o
);

  // Kind register
  logic [KIND_W-1:0] kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_IDENTITY;
    end else if (cfg_we_i) begin
      kind_q <= cfg_wdata_i;
    end
  end

  // Front: sign/magnitude, simple kinds, exponent table lookup
  logic                              fr_valid, fr_ready;
  logic [EXP_DIGITS-1:0][UNIT_W-1:0] fr_fac;
  afu_side_t                         fr_side;

  afu_front u_front (
    .clk_i,
    .rst_ni,
    .kind_i   (kind_q),
    .valid_i  (sample_valid_i),
    .ready_o  (sample_ready_o),
    .sample_i (sample_in_i),
    .valid_o  (fr_valid),
    .ready_i  (fr_ready),
    .fac_o    (fr_fac),
    .side_o   (fr_side)
  );

  // Exponent: e^-|x| (tanh uses e^-2|x|), then denominator 1 + u
  logic [DIV_STAGES:0]              dv, dr;
  logic [DIV_STAGES:0][REM_W-1:0]   drem;
  logic [DIV_STAGES:0][QUO_W-1:0]   dquo;
  logic [DIV_STAGES:0][DEN_W-1:0]   dden;
  afu_side_t                        dside [DIV_STAGES+1];

  afu_exp u_exp (
    .clk_i,
    .rst_ni,
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .fac_i   (fr_fac),
    .side_i  (fr_side),
    .valid_o (dv[0]),
    .ready_i (dr[0]),
    .den_o   (dden[0]),
    .side_o  (dside[0])
  );

  // Reciprocal 1/(1+u): remainder starts at 1.0
  assign drem[0] = REM_W'(UNIT_ONE);
  assign dquo[0] = '0;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    afu_div_stage u_div (
      .clk_i,
      .rst_ni,
      .valid_i (dv[i]),
      .ready_o (dr[i]),
      .rem_i   (drem[i]),
      .quo_i   (dquo[i]),
      .den_i   (dden[i]),
      .side_i  (dside[i]),
      .valid_o (dv[i+1]),
      .ready_i (dr[i+1]),
      .rem_o   (drem[i+1]),
      .quo_o   (dquo[i+1]),
      .den_o   (dden[i+1]),
      .side_o  (dside[i+1])
    );
  end

  // Back end: derivative product, rounding, kind select, output register
  logic [ACT_W-1:0] act_raw;

  afu_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (dv[DIV_STAGES]),
    .ready_o (dr[DIV_STAGES]),
    .quo_i   (dquo[DIV_STAGES]),
    .side_i  (dside[DIV_STAGES]),
    .valid_o (result_valid_o),
    .ready_i (result_ready_i),
    .act_o   (act_raw),
    .slope_o (slope_out_o)
  );

  assign activation_out_o = signed'(act_raw);

endmodule

[src/afu_checker.sv]
module afu_checker import afu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               sample_ready_o,
  input logic               result_valid_o,
  input logic               result_ready_i,
  input logic [ACT_W-1:0]   activation_out_o,
  input logic [SLOPE_W-1:0] slope_out_o
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      result_valid_o && $stable(activation_out_o) && $stable(slope_out_o))
    else $error("stalled result word changed");

  // A free or draining output stage must let the input through
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!result_valid_o || result_ready_i) |-> sample_ready_o)
    else $error("input blocked while output can move");

  // Derivatives never exceed 1.0
  a_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> slope_out_o <= SLOPE_ONE)
    else $error("slope above 1.0");

endmodule

bind activation_function_unit afu_checker u_afu_checker (.*);

[dv/activation_function_unit_test.sv]
`timescale 1ns / 100ps

module activation_function_unit_test import afu_pkg::*; ();

  // Pipeline depth of the block, used for the settle time before a kind change
  localparam int PIPE_LATENCY = 17;

  // Kind codes past the last defined kind; the block must answer these with zeros
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  // Fixed-point scale of the golden math: 2^-54 resolution, 64-bit words
  typedef logic [63:0] u64_t;
  localparam int   GOLD_SHIFT = 54;
  localparam u64_t GOLD_ONE   = u64_t'(1) << GOLD_SHIFT;
  localparam int   SIG_LIMIT  = 1280;  // |x| = 5.0 in Q4.8
  localparam int   MAX_REPORTED = 10;

  typedef struct {
    logic [KIND_W-1:0]            kind;
    logic signed [INPUT_BITS-1:0] sample;
    logic [ACT_W-1:0]             act;
    logic [SLOPE_W-1:0]           slope;
  } activation_expect_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [KIND_W-1:0]            cfg_wdata = '0;
  logic                         sample_valid = 1'b0;
  logic                         sample_ready;
  logic signed [INPUT_BITS-1:0] sample_in = '0;
  logic                         result_valid;
  logic                         result_ready = 1'b0;
  logic signed [ACT_W-1:0]      activation_out;
  logic [SLOPE_W-1:0]           slope_out;

  // Testbench copy of the kind register, updated right after each write
  logic [KIND_W-1:0] active_kind = KIND_IDENTITY;

  activation_expect_t pending_results[$];

  int send_idle_pct  = 38;
  int ready_idle_pct = 38;
  int hold_off_cycles = 0;   // receiver holds ready low this many cycles
  int error_count    = 0;
  int reported_count = 0;
  int words_sent     = 0;
  int words_checked  = 0;

  always #5 clk = ~clk;

  activation_function_unit i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .sample_valid_i   (sample_valid),
    .sample_ready_o   (sample_ready),
    .sample_in_i      (sample_in),
    .result_valid_o   (result_valid),
    .result_ready_i   (result_ready),
    .activation_out_o (activation_out),
    .slope_out_o      (slope_out)
  );

  // ---------------------------------------------------------------------------
  // Golden math. Everything is unsigned 64-bit with 54 fraction bits, matching
  // a table generator that computes the exact value and rounds it once.
  // ---------------------------------------------------------------------------

  // (a * b) >> 54, kept to 64 bits
  function automatic u64_t gold_mul(input u64_t a, input u64_t b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[GOLD_SHIFT+63:GOLD_SHIFT];
  endfunction

  // e^(-r/256) for r in 0..256; Taylor terms summed with separate signs
  function automatic u64_t exp_taylor(input u64_t r);
    u64_t term, pos, neg;
    int n;
    term = GOLD_ONE;
    pos  = GOLD_ONE;
    neg  = '0;
    for (n = 1; n < 40 && term != 0; n++) begin
      term = term * r / (u64_t'(256) * u64_t'(n));
      if (n & 1) neg += term;
      else pos += term;
    end
    return pos - neg;
  endfunction

  // e^(-m/256): fractional part from the series, whole part by repeated e^-1
  function automatic u64_t exp_of_neg(input int unsigned m);
    u64_t e, e_inv;
    e     = exp_taylor(u64_t'(m & 255));
    e_inv = exp_taylor(u64_t'(256));
    repeat (m >> 8) e = gold_mul(e, e_inv);
    return e;
  endfunction

  // round(4096 * num / den), half rounds up
  function automatic u64_t quotient_q12(input u64_t num, input u64_t den);
    u64_t q, rem, twice;
    q   = num / den;
    rem = num % den;
    for (int i = 0; i < Q_FRAC; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | u64_t'(1);
      end
    end
    twice = rem << 1;
    if (twice >= den) q++;
    return q;
  endfunction

  function automatic longint clamp_act(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Expected activation and slope of one sample under the given kind
  function automatic void predict_activation(input logic [KIND_W-1:0] kind,
                                             input logic signed [INPUT_BITS-1:0] x,
                                             output logic [ACT_W-1:0] act,
                                             output logic [SLOPE_W-1:0] slope);
    int          s;
    int unsigned mag, mag_c;
    bit          negv, posv;
    u64_t        e, e2, den, slope_w;
    longint      act_w;
    s     = x;
    negv  = s < 0;
    posv  = s > 0;
    mag   = negv ? -s : s;
    mag_c = (mag > 4095) ? 4095 : mag;
    act_w   = 0;
    slope_w = '0;
    case (kind)
      KIND_IDENTITY: begin
        act_w   = clamp_act(longint'(s) * 16);
        slope_w = 4096;
      end
      KIND_RELU: begin
        // zero takes the negative branch
        act_w   = posv ? clamp_act(longint'(s) * 16) : 0;
        slope_w = posv ? 4096 : 0;
      end
      KIND_LEAKY: begin
        if (posv) begin
          act_w   = clamp_act(longint'(s) * 16);
          slope_w = 4096;
        end else begin
          act_w   = clamp_act(-longint'((16 * longint'(mag) + 5) / 10));
          slope_w = 410;
        end
      end
      KIND_TANH: begin
        e       = exp_of_neg(mag_c);
        e2      = gold_mul(e, e);
        den     = GOLD_ONE + e2;
        act_w   = longint'(quotient_q12(GOLD_ONE - e2, den));
        if (negv) act_w = -act_w;
        slope_w = quotient_q12(u64_t'(4) * e2, gold_mul(den, den));
      end
      KIND_SIGMOID: begin
        e       = exp_of_neg(mag_c);
        den     = GOLD_ONE + e;
        act_w   = longint'(quotient_q12(negv ? e : GOLD_ONE, den));
        // derivative forced to zero beyond |x| = 5, exact value at 5 itself
        slope_w = (mag > SIG_LIMIT) ? '0 : quotient_q12(e, gold_mul(den, den));
      end
      default: begin
        act_w   = 0;
        slope_w = '0;
      end
    endcase
    act   = act_w[ACT_W-1:0];
    slope = slope_w[SLOPE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Valid rises at a falling edge and stays up until the word is
  // taken; the expectation is queued at the accepting rising edge.
  // ---------------------------------------------------------------------------

  task automatic send_sample(input logic signed [INPUT_BITS-1:0] x);
    activation_expect_t exp_word;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      sample_valid <= 1'b0;
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample_in    <= x;
    do @(posedge clk); while (!sample_ready);
    exp_word.kind   = active_kind;
    exp_word.sample = x;
    predict_activation(active_kind, x, exp_word.act, exp_word.slope);
    pending_results.push_back(exp_word);
    words_sent++;
  endtask

  // Drop valid, wait for every queued result, then let the pipe settle
  task automatic drain_pipeline();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  // Kind register is only touched with the pipe empty
  task automatic set_kind(input logic [KIND_W-1:0] kind);
    drain_pipeline();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(negedge clk);
    cfg_we      <= 1'b0;
    active_kind  = kind;
  endtask

  // Mix of full range, values around the sigmoid cutoff and small magnitudes
  function automatic logic signed [INPUT_BITS-1:0] random_sample();
    int v;
    case ($urandom_range(0, 3))
      1: v = SIG_LIMIT - 8 + int'($urandom_range(0, 16));
      2: v = int'($urandom_range(0, 64));
      default: return INPUT_BITS'($urandom_range(0, (1 << INPUT_BITS) - 1));
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return INPUT_BITS'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: ready driven at the falling edge, results checked at the
  // rising edge against the oldest expectation.
  // ---------------------------------------------------------------------------

  task automatic check_result();
    activation_expect_t exp_word;
    if (pending_results.size() == 0) begin
      error_count++;
      if (reported_count < MAX_REPORTED) begin
        reported_count++;
        $display("ERROR: unexpected result word act=%0d slope=%0d",
                 activation_out, slope_out);
      end
      return;
    end
    exp_word = pending_results.pop_front();
    words_checked++;
    if (activation_out !== exp_word.act || slope_out !== exp_word.slope) begin
      error_count++;
      if (reported_count < MAX_REPORTED) begin
        reported_count++;
        $display("ERROR: kind %0d sample %0d: act exp %0d got %0d, slope exp %0d got %0d",
                 exp_word.kind, exp_word.sample, $signed(exp_word.act), activation_out,
                 exp_word.slope, slope_out);
      end
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        result_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
      end
      @(posedge clk);
      if (rst_n && result_valid && result_ready) check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, zero on the relu branches, sigmoid cutoff edges, spare kinds
  task automatic test_directed_corners();
    set_kind(KIND_IDENTITY);
    send_sample(-12'sd2048);
    send_sample(12'sd2047);
    send_sample(12'sd0);
    set_kind(KIND_RELU);
    send_sample(12'sd0);
    send_sample(12'sd1);
    send_sample(-12'sd1);
    set_kind(KIND_LEAKY);
    send_sample(12'sd0);
    send_sample(-12'sd1);
    send_sample(-12'sd2048);
    send_sample(12'sd2047);
    send_sample(-12'sd5);
    set_kind(KIND_TANH);
    send_sample(12'sd0);
    send_sample(12'sd2047);
    send_sample(-12'sd2048);
    send_sample(12'sd256);
    set_kind(KIND_SIGMOID);
    send_sample(12'sd1280);
    send_sample(-12'sd1280);
    send_sample(12'sd1281);
    send_sample(-12'sd1281);
    send_sample(12'sd0);
    send_sample(12'sd2047);
    send_sample(-12'sd2048);
    set_kind(KIND_SPARE_A);
    send_sample(12'sd100);
    set_kind(KIND_SPARE_B);
    send_sample(-12'sd100);
  endtask

  // Random words under a run of kind settings, both sides idling at random
  task automatic test_random_settings();
    logic [KIND_W-1:0] kinds[8];
    kinds = '{KIND_TANH, KIND_SIGMOID, KIND_IDENTITY, KIND_LEAKY,
              KIND_RELU, KIND_SPARE_C, KIND_SIGMOID, KIND_TANH};
    send_idle_pct  = 38;
    ready_idle_pct = 38;
    foreach (kinds[k]) begin
      set_kind(kinds[k]);
      repeat (45) send_sample(random_sample());
    end
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure_fill();
    set_kind(KIND_SIGMOID);
    send_idle_pct   = 0;
    hold_off_cycles = 3 * PIPE_LATENCY + 30;
    repeat (60) send_sample(random_sample());
    send_idle_pct = 38;
  endtask

  // Long stretch with no idling on either side
  task automatic test_steady_stream();
    set_kind(KIND_TANH);
    send_idle_pct  = 0;
    ready_idle_pct = 0;
    repeat (80) send_sample(random_sample());
    send_idle_pct  = 38;
    ready_idle_pct = 38;
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_mid_drain();
    set_kind(KIND_LEAKY);
    repeat (20) send_sample(random_sample());
    drain_pipeline();
    repeat (20) send_sample(random_sample());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_random_settings();
    test_backpressure_fill();
    test_steady_stream();
    test_mid_drain();

    drain_pipeline();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Summary: %0d samples sent, %0d results checked, all eight kind codes,",
             words_sent, words_checked);
    $display("  random stalls, a long result hold-off and a drain pause mid-stream.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
